/* rtl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, operation codes and the word that travels down the pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MODE_BITS  = 3;
   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int VAL_BITS   = SUM_BITS + 1;
   localparam int NUM_BITS   = PROD_BITS + FRAC_BITS;
   localparam int QUO_BITS   = WORD_BITS + 2;
   localparam int ROOT_BITS  = WORD_BITS + 2;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int SREM_BITS  = ROOT_BITS + 3;
   localparam int STEP_BITS  = 2;
   localparam int STEPS      = QUO_BITS / STEP_BITS;

   localparam logic [MODE_BITS-1:0] MODE_ADD = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_SUB = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_MUL = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_DIV = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_MAG = 3'd4;

   typedef struct packed {
      logic                 neg;
      logic                 big;
      logic [PROD_BITS-1:0] rem;
      logic [QUO_BITS-1:0]  low;
      logic [QUO_BITS-1:0]  quo;
   } div_lane_type;

   typedef struct packed {
      logic                       valid;
      logic [MODE_BITS-1:0]       mode;
      logic signed [VAL_BITS-1:0] pre_re;
      logic signed [VAL_BITS-1:0] pre_im;
      logic                       dbz;
      div_lane_type               dre;
      div_lane_type               dim;
      logic [PROD_BITS-1:0]       den;
      logic [RAD_BITS-1:0]        rad;
      logic [SREM_BITS-1:0]       srem;
      logic [ROOT_BITS-1:0]       root;
   } pipe_type;

endpackage

/* rtl/cau_front.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Three register stages: products, product sums, then divider and root setup.
// ----------------------------------------------------------------------------
module cau_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  logic [cau_pkg::MODE_BITS-1:0]       mode,
   input  logic signed [cau_pkg::WORD_BITS-1:0] a_real,
   input  logic signed [cau_pkg::WORD_BITS-1:0] a_imag,
   input  logic signed [cau_pkg::WORD_BITS-1:0] b_real,
   input  logic signed [cau_pkg::WORD_BITS-1:0] b_imag,
   output cau_pkg::pipe_type                   out_word
);
   import cau_pkg::*;

   logic                        v1_ff, v2_ff;
   logic [MODE_BITS-1:0]        mode1_ff, mode2_ff;
   logic signed [PROD_BITS-1:0] prr_ff, pii_ff, pri_ff, pir_ff;
   logic signed [PROD_BITS-1:0] paa_ff, pbb_ff, pdr_ff, pdi_ff;
   logic signed [PROD_BITS-1:0] prr_in, pii_in, pri_in, pir_in;
   logic signed [PROD_BITS-1:0] paa_in, pbb_in, pdr_in, pdi_in;
   logic signed [WORD_BITS:0]   lre_ff, lim_ff, lre_in, lim_in;
   logic signed [WORD_BITS:0]   lre2_ff, lim2_ff;
   logic signed [SUM_BITS-1:0]  mre_ff, mim_ff, nre_ff, nim_ff;
   logic signed [SUM_BITS-1:0]  mre_in, mim_in, nre_in, nim_in;
   logic [PROD_BITS-1:0]        den_ff, msq_ff, den_in, msq_in;
   pipe_type                    out_ff, out_in;

   assign prr_in = a_real * b_real;
   assign pii_in = a_imag * b_imag;
   assign pri_in = a_real * b_imag;
   assign pir_in = a_imag * b_real;
   assign paa_in = a_real * a_real;
   assign pbb_in = a_imag * a_imag;
   assign pdr_in = b_real * b_real;
   assign pdi_in = b_imag * b_imag;
   assign lre_in = (mode == MODE_SUB) ? ((WORD_BITS+1)'(a_real) - (WORD_BITS+1)'(b_real))
                                      : ((WORD_BITS+1)'(a_real) + (WORD_BITS+1)'(b_real));
   assign lim_in = (mode == MODE_SUB) ? ((WORD_BITS+1)'(a_imag) - (WORD_BITS+1)'(b_imag))
                                      : ((WORD_BITS+1)'(a_imag) + (WORD_BITS+1)'(b_imag));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mode1_ff <= mode;
         prr_ff   <= prr_in;
         pii_ff   <= pii_in;
         pri_ff   <= pri_in;
         pir_ff   <= pir_in;
         paa_ff   <= paa_in;
         pbb_ff   <= pbb_in;
         pdr_ff   <= pdr_in;
         pdi_ff   <= pdi_in;
         lre_ff   <= lre_in;
         lim_ff   <= lim_in;
      end
   end

   assign mre_in = SUM_BITS'(prr_ff) - SUM_BITS'(pii_ff);
   assign mim_in = SUM_BITS'(pri_ff) + SUM_BITS'(pir_ff);
   assign nre_in = SUM_BITS'(prr_ff) + SUM_BITS'(pii_ff);
   assign nim_in = SUM_BITS'(pir_ff) - SUM_BITS'(pri_ff);
   assign den_in = PROD_BITS'($unsigned(pdr_ff)) + PROD_BITS'($unsigned(pdi_ff));
   assign msq_in = PROD_BITS'($unsigned(paa_ff)) + PROD_BITS'($unsigned(pbb_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mode2_ff <= mode1_ff;
         mre_ff   <= mre_in;
         mim_ff   <= mim_in;
         nre_ff   <= nre_in;
         nim_ff   <= nim_in;
         den_ff   <= den_in;
         msq_ff   <= msq_in;
         lre2_ff  <= lre_ff;
         lim2_ff  <= lim_ff;
      end
   end

   function automatic logic signed [VAL_BITS-1:0] trunc_shift(logic signed [SUM_BITS-1:0] v);
      logic signed [VAL_BITS-1:0] t;
      t = VAL_BITS'(v);
      if (v < 0) begin
         t = t + VAL_BITS'((1 << FRAC_BITS) - 1);
      end
      return t >>> FRAC_BITS;
   endfunction

   function automatic div_lane_type div_setup(logic signed [SUM_BITS-1:0] n,
                                             logic [PROD_BITS-1:0] d);
      div_lane_type         l;
      logic [PROD_BITS-1:0] m;
      logic [NUM_BITS-1:0]  wide;
      m     = (n < 0) ? PROD_BITS'(-n) : PROD_BITS'(n);
      wide  = {m, {FRAC_BITS{1'b0}}};
      l.neg = n < 0;
      l.big = PROD_BITS'(wide[NUM_BITS-1:QUO_BITS]) >= d;
      l.rem = PROD_BITS'(wide[NUM_BITS-1:QUO_BITS]);
      l.low = wide[QUO_BITS-1:0];
      l.quo = '0;
      return l;
   endfunction

   always_comb begin
      out_in       = out_ff;
      out_in.valid = v2_ff;
      out_in.mode  = mode2_ff;
      if (mode2_ff == MODE_MUL) begin
         out_in.pre_re = trunc_shift(mre_ff);
         out_in.pre_im = trunc_shift(mim_ff);
      end else begin
         out_in.pre_re = VAL_BITS'(lre2_ff);
         out_in.pre_im = VAL_BITS'(lim2_ff);
      end
      out_in.dbz  = den_ff == '0;
      out_in.dre  = div_setup(nre_ff, den_ff);
      out_in.dim  = div_setup(nim_ff, den_ff);
      out_in.den  = den_ff;
      out_in.rad  = RAD_BITS'(msq_ff);
      out_in.srem = '0;
      out_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         out_ff <= out_in;
      end
   end

   assign out_word = out_ff;

endmodule

/* rtl/cau_step.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit iteration stage
// Two quotient bits for each divider lane and two root bits per stage.
// ----------------------------------------------------------------------------
module cau_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  cau_pkg::pipe_type in_word,
   output cau_pkg::pipe_type out_word
);
   import cau_pkg::*;

   pipe_type out_ff, out_in;

   function automatic div_lane_type div_bit(div_lane_type l, logic [PROD_BITS-1:0] d);
      div_lane_type        r;
      logic [PROD_BITS:0]  trial;
      trial = {l.rem, l.low[QUO_BITS-1]};
      r     = l;
      r.low = {l.low[QUO_BITS-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
         r.rem = PROD_BITS'(trial - {1'b0, d});
         r.quo = {l.quo[QUO_BITS-2:0], 1'b1};
      end else begin
         r.rem = trial[PROD_BITS-1:0];
         r.quo = {l.quo[QUO_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      logic [SREM_BITS-1:0] cur;
      logic [SREM_BITS-1:0] trial;
      out_in = in_word;
      for (int k = 0; k < STEP_BITS; k++) begin
         out_in.dre = div_bit(out_in.dre, out_in.den);
         out_in.dim = div_bit(out_in.dim, out_in.den);
         cur   = {out_in.srem[SREM_BITS-3:0], out_in.rad[RAD_BITS-1:RAD_BITS-2]};
         trial = SREM_BITS'({out_in.root, 2'b01});
         out_in.rad = {out_in.rad[RAD_BITS-3:0], 2'b00};
         if (cur >= trial) begin
            out_in.srem = cur - trial;
            out_in.root = {out_in.root[ROOT_BITS-2:0], 1'b1};
         end else begin
            out_in.srem = cur;
            out_in.root = {out_in.root[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         out_ff <= out_in;
      end
   end

   assign out_word = out_ff;

endmodule

/* rtl/cau_back.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Selects the result of the operation, saturates it and holds the output word.
// ----------------------------------------------------------------------------
module cau_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  cau_pkg::pipe_type             in_word,
   output logic                          out_valid,
   output logic [cau_pkg::WORD_BITS-1:0] result_real,
   output logic [cau_pkg::WORD_BITS-1:0] result_imag,
   output logic                          overflow,
   output logic                          divide_by_zero
);
   import cau_pkg::*;

   logic                       valid_ff;
   logic [WORD_BITS-1:0]       re_ff, im_ff, re_in, im_in;
   logic                       ovf_ff, dbz_ff, ovf_in, dbz_in;
   logic signed [VAL_BITS-1:0] vre, vim;
   logic                       ore, oim;

   function automatic logic signed [VAL_BITS-1:0] div_value(div_lane_type l);
      logic signed [VAL_BITS-1:0] v;
      v = l.big ? VAL_BITS'(1) <<< QUO_BITS : VAL_BITS'(l.quo);
      return l.neg ? -v : v;
   endfunction

   function automatic logic [WORD_BITS:0] saturate(logic signed [VAL_BITS-1:0] v);
      logic signed [VAL_BITS-1:0] hi, lo;
      hi = (VAL_BITS'(1) <<< (WORD_BITS - 1)) - VAL_BITS'(1);
      lo = -(VAL_BITS'(1) <<< (WORD_BITS - 1));
      if (v > hi) begin
         return {1'b1, hi[WORD_BITS-1:0]};
      end else if (v < lo) begin
         return {1'b1, lo[WORD_BITS-1:0]};
      end
      return {1'b0, v[WORD_BITS-1:0]};
   endfunction

   always_comb begin
      vre    = '0;
      vim    = '0;
      dbz_in = 1'b0;
      case (in_word.mode)
         MODE_ADD, MODE_SUB, MODE_MUL: begin
            vre = in_word.pre_re;
            vim = in_word.pre_im;
         end
         MODE_DIV: begin
            dbz_in = in_word.dbz;
            if (!in_word.dbz) begin
               vre = div_value(in_word.dre);
               vim = div_value(in_word.dim);
            end
         end
         MODE_MAG: begin
            vre = VAL_BITS'(in_word.root);
         end
         default: begin
            vre = '0;
         end
      endcase
      {ore, re_in} = saturate(vre);
      {oim, im_in} = saturate(vim);
      ovf_in = ore | oim;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_word.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         re_ff  <= re_in;
         im_ff  <= im_in;
         ovf_ff <= ovf_in;
         dbz_ff <= dbz_in;
      end
   end

   assign out_valid      = valid_ff;
   assign result_real    = re_ff;
   assign result_imag    = im_ff;
   assign overflow       = ovf_ff;
   assign divide_by_zero = dbz_ff;

endmodule

/* rtl/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide and magnitude on Q16.16 complex operands.
//
// The req channel carries one operation per word: tuser holds the operation
// and tdata the two complex operands. The rsp channel returns one word per
// request in the same order: tdata holds the saturated result and tuser the
// overflow and divide-by-zero flags.
// A new request is taken every cycle unless the output word waits on rsp_tready.
// From acceptance to rsp_tvalid a request passes three stages of products,
// sums and setup, seventeen stages of the restoring divider and square root,
// which settle two bits each, and the output register.
// The whole pipeline advances together. When the output word waits on
// rsp_tready, req_tready drops and every stage holds its word, so nothing is
// lost or repeated. Reset clears all valid bits; no request is in flight
// afterwards and the block takes a word in the first cycle after reset.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_real, a_imag, b_real, b_imag
   input  logic [127:0] req_tdata,
   // mode
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_real, result_imag
   output logic [63:0]  rsp_tdata,
   // overflow, divide_by_zero
   output logic [1:0]   rsp_tuser
);
   import cau_pkg::*;

   logic     enable;
   pipe_type stage [0:STEPS];

   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable && !reset;

   cau_front front (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_tvalid),
      .mode     (req_tuser),
      .a_real   (req_tdata[WORD_BITS-1:0]),
      .a_imag   (req_tdata[2*WORD_BITS-1:WORD_BITS]),
      .b_real   (req_tdata[3*WORD_BITS-1:2*WORD_BITS]),
      .b_imag   (req_tdata[4*WORD_BITS-1:3*WORD_BITS]),
      .out_word (stage[0])
   );

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      cau_step step (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .in_word  (stage[g]),
         .out_word (stage[g+1])
      );
   end

   cau_back back (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .in_word        (stage[STEPS]),
      .out_valid      (rsp_tvalid),
      .result_real    (rsp_tdata[WORD_BITS-1:0]),
      .result_imag    (rsp_tdata[2*WORD_BITS-1:WORD_BITS]),
      .overflow       (rsp_tuser[0]),
      .divide_by_zero (rsp_tuser[1])
   );

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0 && !rsp_tuser[0])
      else $error("divide by zero with nonzero result");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(stage[STEPS]) && $stable(stage[0]))
      else $error("pipeline moved during stall");

   a_mag_imag: assert property (@(posedge clock) disable iff (reset)
      enable && stage[STEPS].valid && stage[STEPS].mode == MODE_MAG
      |=> rsp_tdata[2*WORD_BITS-1:WORD_BITS] == '0)
      else $error("magnitude with nonzero imaginary part");

   a_valid_out: assert property (@(posedge clock) disable iff (reset)
      enable |=> rsp_tvalid == $past(stage[STEPS].valid))
      else $error("output valid lost");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Streams directed and random operations through the block under random
// idling and stall on both channels. A scoreboard predicts each saturated
// Q16.16 result from the request word and checks the responses in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cau_pkg::*;

   localparam logic [MODE_BITS-1:0] MODE_UNUSED_5 = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED_6 = 3'd6;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED_7 = 3'd7;
   localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;
   localparam logic signed [31:0] Q_ONE = 32'sh00010000;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               ovf;
      logic               dbz;
   } result_type;

   class alu_scoreboard;
      result_type expected_results[$];
      int         mismatches;

      function new();
         mismatches = 0;
      endfunction

      function logic [31:0] clip(input wide_type v, inout logic ovf);
         if (v > wide_type'(Q_MAX)) begin
            ovf = 1'b1;
            return Q_MAX;
         end
         if (v < wide_type'(Q_MIN)) begin
            ovf = 1'b1;
            return Q_MIN;
         end
         return v[31:0];
      endfunction

      function wide_type shift_toward_zero(input wide_type v);
         if (v < 0) return -((-v) >>> FRAC_BITS);
         return v >>> FRAC_BITS;
      endfunction

      function wide_type quotient(input wide_type n, input logic [127:0] d);
         logic [127:0] m;
         m = (n < 0) ? -n : n;
         m = (m << FRAC_BITS) / d;
         return (n < 0) ? -wide_type'(m) : wide_type'(m);
      endfunction

      function wide_type root(input logic [127:0] x);
         logic [127:0] r, c;
         r = 0;
         for (int i = 33; i >= 0; i--) begin
            c = r | (128'd1 << i);
            if (c * c <= x) r = c;
         end
         return wide_type'(r);
      endfunction

      function result_type complex_result(input logic [2:0] mode,
                                          input logic signed [31:0] a_re,
                                          input logic signed [31:0] a_im,
                                          input logic signed [31:0] b_re,
                                          input logic signed [31:0] b_im);
         wide_type   ar, ai, br, bi, re, im;
         logic [127:0] d;
         result_type r;
         ar = a_re; ai = a_im; br = b_re; bi = b_im;
         re = 0; im = 0;
         r.ovf = 1'b0;
         r.dbz = 1'b0;
         case (mode)
            MODE_ADD: begin
               re = ar + br;
               im = ai + bi;
            end
            MODE_SUB: begin
               re = ar - br;
               im = ai - bi;
            end
            MODE_MUL: begin
               re = shift_toward_zero(ar * br - ai * bi);
               im = shift_toward_zero(ar * bi + ai * br);
            end
            MODE_DIV: begin
               d = br * br + bi * bi;
               if (d == 0) begin
                  r.dbz = 1'b1;
               end else begin
                  re = quotient(ar * br + ai * bi, d);
                  im = quotient(ai * br - ar * bi, d);
               end
            end
            MODE_MAG: begin
               re = root(ar * ar + ai * ai);
            end
            default: ;
         endcase
         r.re = clip(re, r.ovf);
         r.im = clip(im, r.ovf);
         return r;
      endfunction

      function void note_request(input logic [2:0] mode, input logic [127:0] data);
         expected_results.push_back(complex_result(mode, data[31:0], data[63:32],
                                                   data[95:64], data[127:96]));
      endfunction

      function void report_mismatch(input string what, input logic [31:0] got,
                                    input logic [31:0] want);
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
         mismatches++;
      endfunction

      function void check_response(input logic [63:0] data, input logic [1:0] user);
         result_type e;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected word", data[31:0], 0);
            return;
         end
         e = expected_results.pop_front();
         if (data[31:0] !== e.re) report_mismatch("result_real", data[31:0], e.re);
         if (data[63:32] !== e.im) report_mismatch("result_imag", data[63:32], e.im);
         if (user[0] !== e.ovf) report_mismatch("overflow", user[0], e.ovf);
         if (user[1] !== e.dbz) report_mismatch("divide_by_zero", user[1], e.dbz);
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   alu_scoreboard scoreboard = new();
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;

   complex_arithmetic_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      rsp_tready = 1'b0;
      hold_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) scoreboard.check_response(rsp_tdata, rsp_tuser);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_word(input logic [2:0] mode, input logic signed [31:0] a_re,
                            input logic signed [31:0] a_im, input logic signed [31:0] b_re,
                            input logic signed [31:0] b_im);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {b_im, b_re, a_im, a_re};
      do @(posedge clock); while (!req_tready);
      scoreboard.note_request(mode, {b_im, b_re, a_im, a_re});
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (scoreboard.expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(4))
         0: return $urandom;
         1: return $urandom_range(2097151) - 1048576;
         2: case ($urandom_range(4))
               0: return 0;
               1: return 32'sd1;
               2: return -32'sd1;
               3: return Q_MAX;
               default: return Q_MIN;
            endcase
         3: return ($urandom_range(255) - 128) << FRAC_BITS;
         default: return $urandom_range(16777215) - 8388608;
      endcase
   endfunction

   task automatic send_random(input int count);
      logic [2:0] mode;
      logic signed [31:0] br, bi;
      for (int n = 0; n < count; n++) begin
         mode = 3'($urandom_range(7));
         br = random_operand();
         bi = random_operand();
         if (mode == MODE_DIV && $urandom_range(9) == 0) begin
            br = 0;
            bi = 0;
         end
         send_word(mode, random_operand(), random_operand(), br, bi);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_ADD;
      send_idle_pct = 8;
      recv_idle_pct = 48;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_word(MODE_ADD, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
      send_word(MODE_ADD, Q_ONE, -Q_ONE, 32'sd5, 32'sd7);
      send_word(MODE_SUB, Q_MIN, Q_MAX, Q_MAX, Q_MIN);
      send_word(MODE_SUB, Q_ONE, 0, Q_ONE, 0);
      send_word(MODE_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      send_word(MODE_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
      send_word(MODE_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1);
      send_word(MODE_MUL, 2 * Q_ONE, 3 * Q_ONE, -Q_ONE, Q_ONE);
      send_word(MODE_DIV, Q_ONE, Q_ONE, 0, 0);
      send_word(MODE_DIV, Q_MIN, Q_MIN, 32'sd1, 0);
      send_word(MODE_DIV, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
      send_word(MODE_DIV, -Q_ONE, 32'sd3, 0, -32'sd1);
      send_word(MODE_DIV, 3 * Q_ONE, 4 * Q_ONE, Q_ONE, 2 * Q_ONE);
      send_word(MODE_MAG, Q_MIN, Q_MIN, 0, 0);
      send_word(MODE_MAG, 3 * Q_ONE, -4 * Q_ONE, Q_MAX, Q_MAX);
      send_word(MODE_MAG, 0, 0, 0, 0);
      send_word(MODE_MAG, Q_MAX, 0, 0, 0);
      send_word(MODE_UNUSED_5, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
      send_word(MODE_UNUSED_6, Q_ONE, Q_ONE, 0, 0);
      send_word(MODE_UNUSED_7, -32'sd1, -32'sd1, -32'sd1, -32'sd1);

      send_random(500);
      wait_drained();
      send_idle_pct = 48;
      recv_idle_pct = 8;
      send_random(500);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 200;
      send_random(530);
      wait_drained();
      repeat (30) @(posedge clock);

      if (scoreboard.mismatches == 0 && scoreboard.expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule

/* files.f */
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_step.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
bench/testbench.sv
